[sv/mpf_pkg.sv]
package mpf_pkg;

   // Panel geometry and font shape.
   localparam int COLUMNS      = 128;
   localparam int PAGES        = 4;
   localparam int GLYPH_WIDTH  = 6;
   localparam int FONT_COLS    = 6;
   localparam int FONT_ENTRIES = 39;
   localparam int STORE_SIZE   = COLUMNS * PAGES;
   localparam int STORE_ADDR_W = $clog2(STORE_SIZE);
   localparam int COL_SUM_W    = 9;
   localparam int CNT_W        = 3;
   localparam int FRAME_CMDS   = 4;

   // Operation codes of the op field.
   localparam logic [2:0] OP_SET    = 3'd0;
   localparam logic [2:0] OP_CLEAR  = 3'd1;
   localparam logic [2:0] OP_INVERT = 3'd2;
   localparam logic [2:0] OP_PRINT  = 3'd3;
   localparam logic [2:0] OP_FETCH  = 3'd4;

   // Panel command bytes sent ahead of a column 0 fetch.
   localparam logic [7:0] CMD_PAGE_ADDR = 8'h22;
   localparam logic [7:0] CMD_COL_LOW   = 8'h00;
   localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

   // Character to font entry mapping.
   localparam logic [7:0] CHAR_DOT    = 8'h2e;
   localparam logic [7:0] CHAR_COLON  = 8'h3a;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_A      = 8'h41;
   localparam logic [7:0] CHAR_Z      = 8'h5a;
   localparam logic [7:0] DIGIT_BIAS  = CHAR_ZERO - 8'd2;
   localparam logic [7:0] ALPHA_BIAS  = CHAR_A - 8'd13;
   localparam logic [5:0] GLYPH_BLANK = 6'd0;
   localparam logic [5:0] GLYPH_DOT   = 6'd1;
   localparam logic [5:0] GLYPH_COLON = 6'd12;

   // One row per entry, font column 0 in the top byte.
   localparam logic [FONT_COLS*8-1:0] FONT_TABLE [FONT_ENTRIES] = '{
      48'h000000000000, 48'h000002000000, 48'h003c4a523c00, 48'h00227e020000,
      48'h00264a522600, 48'h002442522c00, 48'h007010107e00, 48'h006452524c00,
      48'h003c52520c00, 48'h004046487000, 48'h002c52522c00, 48'h00304a4a3c00,
      48'h000024000000, 48'h003e50503e00, 48'h007e52522c00, 48'h003c42422400,
      48'h007e42423c00, 48'h007e52524200, 48'h007e50500000, 48'h003c424a0c00,
      48'h007e10107e00, 48'h00427e420000, 48'h000402027c00, 48'h007e10284600,
      48'h007e02020200, 48'h007e2010207e, 48'h007e20107e00, 48'h003c42423c00,
      48'h007e50502000, 48'h003c42443a00, 48'h007e50502e00, 48'h002452524c00,
      48'h0040407e4040, 48'h007c02027c00, 48'h00601c021c60, 48'h007e0408047e,
      48'h004628102846, 48'h0040201e2040, 48'h00464a526200
   };

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_WRITE,
      ST_CLEAR,
      ST_FRAME,
      ST_FETCH_OUT
   } state_type;

   typedef enum logic [1:0] {
      ALU_ZERO,
      ALU_PIXEL,
      ALU_INVERT,
      ALU_OR
   } alu_op_type;

   typedef struct packed {
      logic [2:0] op;
      logic [6:0] column;
      logic [4:0] row;
      logic [1:0] page;
      logic       pixel_value;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic                    wr_en;
      logic [STORE_ADDR_W-1:0] addr;
      alu_op_type              alu_op;
      logic [7:0]              operand;
      logic                    bit_val;
   } store_ctrl_type;

   function automatic logic [STORE_ADDR_W-1:0] store_addr(
      input logic [COL_SUM_W-1:0] col,
      input logic [2:0]           page
   );
      return STORE_ADDR_W'(int'(col) * PAGES + int'(page));
   endfunction

   function automatic logic [5:0] glyph_index(input logic [7:0] ch);
      logic [5:0] g;
      g = GLYPH_BLANK;
      if (ch == CHAR_DOT) begin
         g = GLYPH_DOT;
      end else if (ch == CHAR_COLON) begin
         g = GLYPH_COLON;
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         g = 6'(ch - DIGIT_BIAS);
      end else if (ch >= CHAR_A && ch <= CHAR_Z) begin
         g = 6'(ch - ALPHA_BIAS);
      end
      return g;
   endfunction

   function automatic logic [7:0] glyph_column(
      input logic [5:0]       g,
      input logic [CNT_W-1:0] i
   );
      logic [7:0] bits;
      bits = 8'h00;
      if (int'(i) < FONT_COLS) begin
         bits = FONT_TABLE[g][(FONT_COLS - 1 - int'(i)) * 8 +: 8];
      end
      return bits;
   endfunction

   function automatic logic [7:0] bit_mirror(input logic [7:0] b);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
         r[7 - k] = b[k];
      end
      return r;
   endfunction

   function automatic logic [7:0] frame_cmd(
      input logic [1:0] idx,
      input logic [1:0] page
   );
      logic [7:0] b;
      case (idx)
         2'd0: b = CMD_PAGE_ADDR;
         2'd1: b = 8'(page);
         2'd2: b = CMD_COL_LOW;
         default: b = CMD_COL_HIGH;
      endcase
      return b;
   endfunction

endpackage

[sv/mpf_store.sv]
module mpf_store (
   input  logic                   clock,
   input  mpf_pkg::store_ctrl_type ctrl,
   output logic [7:0]             rd_data
);

   logic [7:0] mem [mpf_pkg::STORE_SIZE];
   logic [7:0] rd_data_ff;
   logic [7:0] wr_data;

   // Byte modify unit shared by every read-modify-write and the clearing sweeps.
   always_comb begin
      case (ctrl.alu_op)
         mpf_pkg::ALU_ZERO:   wr_data = 8'h00;
         mpf_pkg::ALU_PIXEL:  wr_data = (rd_data_ff & ~ctrl.operand) |
                                        (ctrl.bit_val ? ctrl.operand : 8'h00);
         mpf_pkg::ALU_INVERT: wr_data = ~rd_data_ff;
         mpf_pkg::ALU_OR:     wr_data = rd_data_ff | ctrl.operand;
         default:             wr_data = 8'h00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[ctrl.addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/mono_page_framebuffer.sv]
// Page-ordered monochrome frame store of 128 columns by 4 pages, one byte per column
// per page, with bit k of a byte holding row page*8+k. An item is taken when start is
// high and busy is low; its results appear on rsp_item for one cycle each, marked by
// rsp_strobe, and must be taken as they come since the block cannot be held off.
// After reset the block is busy while it sweeps the store to zero.
// Every operation is built from one registered-read byte memory port and one shared
// byte modify unit, driven by a small sequencer, so an item is made of read and
// write steps: a set pixel reads and rewrites its byte; a glyph reads and writes
// each drawn column; a store clear writes every byte; an invert reads and writes
// every byte; a fetch reads and sends its byte, at column 0 after four command
// beats. Unused codes, disabled inverts and out-of-range requests answer on the
// cycle after acceptance and leave busy low, so the next item may follow at once.
// The invert_enable register is written through csr_wr_en and csr_wr_data.
module mono_page_framebuffer (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  mpf_pkg::req_type req_item,
   output logic            rsp_strobe,
   output mpf_pkg::rsp_type rsp_item,
   input  logic            csr_wr_en,
   input  logic            csr_wr_data
);

   localparam logic [mpf_pkg::STORE_ADDR_W-1:0] LAST_ADDR =
      mpf_pkg::STORE_ADDR_W'(mpf_pkg::STORE_SIZE - 1);

   mpf_pkg::state_type state_ff, state_in;
   mpf_pkg::req_type   req_ff, req_in;
   mpf_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [mpf_pkg::STORE_ADDR_W-1:0] addr_ff, addr_in;
   logic [mpf_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic               invert_ff;

   mpf_pkg::store_ctrl_type store_ctrl;
   logic [7:0]              store_rdata;

   // Next glyph column and next glyph step, one wider than needed to catch the edge.
   logic [mpf_pkg::COL_SUM_W-1:0] glyph_col_next;
   logic [mpf_pkg::CNT_W:0]       cnt_next;

   assign glyph_col_next = mpf_pkg::COL_SUM_W'(req_ff.column) +
                           mpf_pkg::COL_SUM_W'(cnt_ff) + mpf_pkg::COL_SUM_W'(1);
   assign cnt_next = {1'b0, cnt_ff} + {{mpf_pkg::CNT_W{1'b0}}, 1'b1};

   mpf_store u_store (
      .clock   (clock),
      .ctrl    (store_ctrl),
      .rd_data (store_rdata)
   );

   // Register state, the latched item, the store pointer and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mpf_pkg::ST_INIT;
         addr_ff       <= '0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
         invert_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         addr_ff       <= addr_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            invert_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // Sequencer: decodes an accepted item and then steps the shared store port.
   always_comb begin
      state_in           = state_ff;
      req_in             = req_ff;
      addr_in            = addr_ff;
      cnt_in             = cnt_ff;
      rsp_strobe_in      = 1'b0;
      rsp_in.out_byte    = 8'h00;
      rsp_in.is_data     = 1'b0;
      rsp_in.last        = 1'b1;
      store_ctrl.wr_en   = 1'b0;
      store_ctrl.addr    = addr_ff;
      store_ctrl.alu_op  = mpf_pkg::ALU_ZERO;
      store_ctrl.operand = 8'h00;
      store_ctrl.bit_val = 1'b0;

      case (state_ff)
         mpf_pkg::ST_INIT: begin
            // Power-on sweep: zero one byte a cycle, no beat at the end.
            store_ctrl.wr_en = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = mpf_pkg::ST_IDLE;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         mpf_pkg::ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               cnt_in = '0;
               case (req_item.op)
                  mpf_pkg::OP_SET: begin
                     if (int'(req_item.column) < mpf_pkg::COLUMNS &&
                         int'(req_item.row) < mpf_pkg::PAGES * 8) begin
                        addr_in  = mpf_pkg::store_addr(
                                      mpf_pkg::COL_SUM_W'(req_item.column),
                                      3'(req_item.row >> 3));
                        state_in = mpf_pkg::ST_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  mpf_pkg::OP_CLEAR: begin
                     addr_in  = '0;
                     state_in = mpf_pkg::ST_CLEAR;
                  end
                  mpf_pkg::OP_INVERT: begin
                     if (invert_ff) begin
                        addr_in  = '0;
                        state_in = mpf_pkg::ST_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  mpf_pkg::OP_PRINT: begin
                     if (int'(req_item.column) < mpf_pkg::COLUMNS &&
                         int'(req_item.page) < mpf_pkg::PAGES) begin
                        addr_in  = mpf_pkg::store_addr(
                                      mpf_pkg::COL_SUM_W'(req_item.column),
                                      3'(req_item.page));
                        state_in = mpf_pkg::ST_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  mpf_pkg::OP_FETCH: begin
                     if (int'(req_item.column) < mpf_pkg::COLUMNS &&
                         int'(req_item.page) < mpf_pkg::PAGES) begin
                        addr_in  = mpf_pkg::store_addr(
                                      mpf_pkg::COL_SUM_W'(req_item.column),
                                      3'(req_item.page));
                        state_in = (req_item.column == '0) ? mpf_pkg::ST_FRAME
                                                           : mpf_pkg::ST_READ;
                     end else begin
                        // Fetch off the panel answers with a single zero data byte.
                        rsp_strobe_in  = 1'b1;
                        rsp_in.is_data = 1'b1;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         mpf_pkg::ST_READ: begin
            // The store latches the byte at addr_ff on this edge.
            state_in = (req_ff.op == mpf_pkg::OP_FETCH) ? mpf_pkg::ST_FETCH_OUT
                                                        : mpf_pkg::ST_WRITE;
         end

         mpf_pkg::ST_WRITE: begin
            store_ctrl.wr_en = 1'b1;
            state_in         = mpf_pkg::ST_IDLE;
            rsp_strobe_in    = 1'b1;
            case (req_ff.op)
               mpf_pkg::OP_SET: begin
                  store_ctrl.alu_op  = mpf_pkg::ALU_PIXEL;
                  store_ctrl.operand = 8'h01 << req_ff.row[2:0];
                  store_ctrl.bit_val = req_ff.pixel_value;
               end
               mpf_pkg::OP_INVERT: begin
                  store_ctrl.alu_op = mpf_pkg::ALU_INVERT;
                  if (addr_ff != LAST_ADDR) begin
                     addr_in       = addr_ff + 1'b1;
                     state_in      = mpf_pkg::ST_READ;
                     rsp_strobe_in = 1'b0;
                  end
               end
               mpf_pkg::OP_PRINT: begin
                  store_ctrl.alu_op  = mpf_pkg::ALU_OR;
                  store_ctrl.operand = mpf_pkg::bit_mirror(mpf_pkg::glyph_column(
                                          mpf_pkg::glyph_index(req_ff.char_code),
                                          cnt_ff));
                  // Stop after the last glyph column or at the right edge.
                  if (int'(cnt_next) < mpf_pkg::GLYPH_WIDTH &&
                      int'(glyph_col_next) < mpf_pkg::COLUMNS) begin
                     cnt_in        = mpf_pkg::CNT_W'(cnt_next);
                     addr_in       = mpf_pkg::store_addr(glyph_col_next,
                                                         3'(req_ff.page));
                     state_in      = mpf_pkg::ST_READ;
                     rsp_strobe_in = 1'b0;
                  end
               end
               default: begin
                  store_ctrl.wr_en = 1'b0;
               end
            endcase
         end

         mpf_pkg::ST_CLEAR: begin
            store_ctrl.wr_en = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in       = '0;
               state_in      = mpf_pkg::ST_IDLE;
               rsp_strobe_in = 1'b1;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end

         mpf_pkg::ST_FRAME: begin
            // Four command beats ahead of a column 0 fetch.
            rsp_strobe_in   = 1'b1;
            rsp_in.out_byte = mpf_pkg::frame_cmd(cnt_ff[1:0], req_ff.page);
            rsp_in.last     = 1'b0;
            cnt_in          = cnt_ff + 1'b1;
            if (int'(cnt_ff) == mpf_pkg::FRAME_CMDS - 1) begin
               state_in = mpf_pkg::ST_READ;
            end
         end

         mpf_pkg::ST_FETCH_OUT: begin
            rsp_strobe_in   = 1'b1;
            rsp_in.out_byte = store_rdata;
            rsp_in.is_data  = 1'b1;
            state_in        = mpf_pkg::ST_IDLE;
         end

         default: begin
            state_in = mpf_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != mpf_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // An accepted item either keeps the block busy or answers on the next cycle.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("accepted item neither started work nor answered");

   // Only the final beat of an item may show while the block is idle.
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> busy)
      else $error("non-final beat while idle");

   // Data beats always close their item.
   a_data_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.is_data |-> rsp_item.last)
      else $error("data beat without last");

   // The store is never written while the block is idle.
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      store_ctrl.wr_en |-> busy)
      else $error("store write while idle");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
   import mpf_pkg::*;

   // Codes above OP_FETCH do nothing but earn an acknowledge beat.
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   // Font entries of the special characters and the first entries of each run.
   localparam int FONT_DOT        = 1;
   localparam int FONT_COLON      = 12;
   localparam int FONT_DIGIT_BASE = 2;
   localparam int FONT_ALPHA_BASE = 13;

   localparam int CYCLE_LIMIT = 1_200_000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;
   logic    csr_wr_en = 1'b0;
   logic    csr_wr_data = 1'b0;

   // Shadow state of the block: the frame store and the invert register.
   logic [7:0] frame_copy [STORE_SIZE];
   logic       invert_on;

   req_type pending_cmds [$];
   rsp_type expected_beats [$];

   int          gap_left = 0;
   logic        steady_feed = 1'b0;
   int          queued_items = 0;
   int          errors = 0;
   int unsigned cycle_count = 0;

   // Printable characters that have a glyph in the font.
   string charset = ".:0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

   mono_page_framebuffer u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor.
   // ---------------------------------------------------------------------------

   // Font rows hold glyph column 0 in the top byte; the low bit of each column
   // byte is the bottom of the glyph, so columns are mirrored when drawn.
   function automatic logic [47:0] font_row(input int g);
      logic [47:0] r;
      case (g)
         1:  r = 48'h000002000000;
         2:  r = 48'h003c4a523c00;
         3:  r = 48'h00227e020000;
         4:  r = 48'h00264a522600;
         5:  r = 48'h002442522c00;
         6:  r = 48'h007010107e00;
         7:  r = 48'h006452524c00;
         8:  r = 48'h003c52520c00;
         9:  r = 48'h004046487000;
         10: r = 48'h002c52522c00;
         11: r = 48'h00304a4a3c00;
         12: r = 48'h000024000000;
         13: r = 48'h003e50503e00;
         14: r = 48'h007e52522c00;
         15: r = 48'h003c42422400;
         16: r = 48'h007e42423c00;
         17: r = 48'h007e52524200;
         18: r = 48'h007e50500000;
         19: r = 48'h003c424a0c00;
         20: r = 48'h007e10107e00;
         21: r = 48'h00427e420000;
         22: r = 48'h000402027c00;
         23: r = 48'h007e10284600;
         24: r = 48'h007e02020200;
         25: r = 48'h007e2010207e;
         26: r = 48'h007e20107e00;
         27: r = 48'h003c42423c00;
         28: r = 48'h007e50502000;
         29: r = 48'h003c42443a00;
         30: r = 48'h007e50502e00;
         31: r = 48'h002452524c00;
         32: r = 48'h0040407e4040;
         33: r = 48'h007c02027c00;
         34: r = 48'h00601c021c60;
         35: r = 48'h007e0408047e;
         36: r = 48'h004628102846;
         37: r = 48'h0040201e2040;
         38: r = 48'h00464a526200;
         default: r = 48'h000000000000;
      endcase
      return r;
   endfunction

   function automatic int font_entry(input logic [7:0] ch);
      int g;
      g = 0;
      if (ch == CHAR_DOT) begin
         g = FONT_DOT;
      end else if (ch == CHAR_COLON) begin
         g = FONT_COLON;
      end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         g = int'(ch - CHAR_ZERO) + FONT_DIGIT_BASE;
      end else if (ch >= CHAR_A && ch <= CHAR_Z) begin
         g = int'(ch - CHAR_A) + FONT_ALPHA_BASE;
      end
      return g;
   endfunction

   function automatic logic [7:0] flip_bits(input logic [7:0] b);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
         r[k] = b[7 - k];
      end
      return r;
   endfunction

   task automatic push_beat(input logic [7:0] b, input logic data, input logic tail);
      rsp_type beat;
      beat.out_byte = b;
      beat.is_data  = data;
      beat.last     = tail;
      expected_beats.push_back(beat);
   endtask

   // Applies one accepted command to the shadow store and queues its beats.
   task automatic apply_command(input req_type c);
      int          col;
      int          idx;
      int          g;
      logic [7:0]  bits;
      logic [47:0] glyph;
      col = int'(c.column);
      case (c.op)
         OP_SET: begin
            if (col < COLUMNS && int'(c.row) < PAGES * 8) begin
               idx = col * PAGES + int'(c.row[4:3]);
               frame_copy[idx][c.row[2:0]] = c.pixel_value;
            end
            push_beat(8'h00, 1'b0, 1'b1);
         end
         OP_CLEAR: begin
            for (int i = 0; i < STORE_SIZE; i++) begin
               frame_copy[i] = 8'h00;
            end
            push_beat(8'h00, 1'b0, 1'b1);
         end
         OP_INVERT: begin
            if (invert_on) begin
               for (int i = 0; i < STORE_SIZE; i++) begin
                  frame_copy[i] = ~frame_copy[i];
               end
            end
            push_beat(8'h00, 1'b0, 1'b1);
         end
         OP_PRINT: begin
            if (col < COLUMNS && int'(c.page) < PAGES) begin
               g = font_entry(c.char_code);
               glyph = font_row(g);
               for (int i = 0; i < GLYPH_WIDTH && col + i < COLUMNS; i++) begin
                  bits = (i < FONT_COLS) ? glyph[47 - 8 * i -: 8] : 8'h00;
                  idx = (col + i) * PAGES + int'(c.page);
                  frame_copy[idx] = frame_copy[idx] | flip_bits(bits);
               end
            end
            push_beat(8'h00, 1'b0, 1'b1);
         end
         OP_FETCH: begin
            if (col >= COLUMNS || int'(c.page) >= PAGES) begin
               push_beat(8'h00, 1'b1, 1'b1);
            end else begin
               // Column 0 fetches open with the page and column address commands.
               if (col == 0) begin
                  push_beat(CMD_PAGE_ADDR, 1'b0, 1'b0);
                  push_beat(8'(c.page), 1'b0, 1'b0);
                  push_beat(CMD_COL_LOW, 1'b0, 1'b0);
                  push_beat(CMD_COL_HIGH, 1'b0, 1'b0);
               end
               push_beat(frame_copy[col * PAGES + int'(c.page)], 1'b1, 1'b1);
            end
         end
         default: begin
            push_beat(8'h00, 1'b0, 1'b1);
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Driver. A command is accepted at an edge where start is high and busy is
   // low; it is predicted right there. The next command, or an idle gap, is chosen
   // whenever the request slot is free.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      req_type nxt;
      logic    take;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_command(req_item);
         end
         if (!start || !busy) begin
            take = 1'b0;
            nxt  = '0;
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
            end else if (pending_cmds.size() != 0) begin
               if (!steady_feed && $urandom_range(0, 4) == 0) begin
                  gap_left <= $urandom_range(0, 2);
               end else begin
                  take = 1'b1;
                  nxt  = pending_cmds.pop_front();
               end
            end
            start <= take;
            if (take) begin
               req_item <= nxt;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor. Every strobed response beat must match the oldest prediction.
   // ---------------------------------------------------------------------------
   task automatic note_mismatch(input string field, input int want, input int got);
      $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
      errors++;
   endtask

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_beats.size() == 0) begin
            $error("response beat 0x%0h with nothing expected", rsp_item);
            errors++;
         end else begin
            want = expected_beats.pop_front();
            if (rsp_item.out_byte !== want.out_byte)
               note_mismatch("out_byte", want.out_byte, rsp_item.out_byte);
            if (rsp_item.is_data !== want.is_data)
               note_mismatch("is_data", want.is_data, rsp_item.is_data);
            if (rsp_item.last !== want.last)
               note_mismatch("last", want.last, rsp_item.last);
         end
      end
   end

   // Hard stop in case the block hangs or drops beats.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------

   // A command with every field random; callers override what matters.
   function automatic req_type random_cmd();
      req_type c;
      c.op          = 3'($urandom_range(0, 7));
      c.column      = 7'($urandom_range(0, 127));
      c.row         = 5'($urandom_range(0, 31));
      c.page        = 2'($urandom_range(0, 3));
      c.pixel_value = 1'($urandom_range(0, 1));
      c.char_code   = 8'($urandom_range(0, 255));
      return c;
   endfunction

   // Only commands that actually do something count toward the run length.
   task automatic push_cmd(input req_type c);
      pending_cmds.push_back(c);
      if (c.op <= OP_FETCH && !(c.op == OP_INVERT && !invert_on))
         queued_items++;
   endtask

   task automatic queue_cmd(input logic [2:0] op, input int col, input int row,
                            input int pg, input logic val, input logic [7:0] ch);
      req_type c;
      c.op          = op;
      c.column      = 7'(col);
      c.row         = 5'(row);
      c.page        = 2'(pg);
      c.pixel_value = val;
      c.char_code   = ch;
      push_cmd(c);
   endtask

   function automatic logic [7:0] pick_char();
      logic [7:0] ch;
      if ($urandom_range(0, 4) == 0)
         ch = 8'($urandom_range(0, 255));
      else
         ch = charset[$urandom_range(0, charset.len() - 1)];
      return ch;
   endfunction

   // A string printed the way the host does it, one glyph per command with the
   // column stepping by the glyph width, then a few reads of what was drawn.
   task automatic queue_text();
      req_type c;
      int      col0;
      int      len;
      int      pg;
      int      n;
      col0 = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, COLUMNS - 1);
      len  = $urandom_range(1, 6);
      pg   = $urandom_range(0, PAGES - 1);
      n    = 0;
      while (n < len && col0 + GLYPH_WIDTH * n < COLUMNS) begin
         c           = random_cmd();
         c.op        = OP_PRINT;
         c.page      = 2'(pg);
         c.column    = 7'(col0 + GLYPH_WIDTH * n);
         c.char_code = pick_char();
         push_cmd(c);
         n++;
      end
      repeat ($urandom_range(1, 3)) begin
         c        = random_cmd();
         c.op     = OP_FETCH;
         c.page   = 2'(pg);
         c.column = 7'((col0 + $urandom_range(0, GLYPH_WIDTH * n - 1)) % COLUMNS);
         push_cmd(c);
      end
   endtask

   // A few pixel writes followed by a read of the byte that the last one hit.
   task automatic queue_pixels();
      req_type c;
      repeat ($urandom_range(1, 4)) begin
         c    = random_cmd();
         c.op = OP_SET;
         push_cmd(c);
      end
      c.op   = OP_FETCH;
      c.page = c.row[4:3];
      push_cmd(c);
   endtask

   task automatic queue_random(input int count);
      req_type c;
      int      pick;
      int      goal;
      goal = queued_items + count;
      while (queued_items < goal) begin
         pick = $urandom_range(0, 99);
         c    = random_cmd();
         if (pick < 35) begin
            queue_text();
         end else if (pick < 60) begin
            queue_pixels();
         end else if (pick < 75) begin
            c.op = OP_FETCH;
            if ($urandom_range(0, 3) == 0)
               c.column = '0;
            push_cmd(c);
         end else if (pick < 83) begin
            c.op = OP_INVERT;
            push_cmd(c);
         end else if (pick < 87) begin
            c.op = OP_CLEAR;
            push_cmd(c);
         end else if (pick < 93) begin
            c.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
            push_cmd(c);
         end else begin
            // Pure noise: any code, any field values.
            push_cmd(c);
         end
      end
   endtask

   // Waits until every command has been accepted and answered, then lets the
   // block settle before anything else happens.
   task automatic wait_drained();
      while (pending_cmds.size() != 0 || start || expected_beats.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   task automatic write_invert(input logic v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      invert_on = v;
   endtask

   // ---------------------------------------------------------------------------
   // Test sequence.
   // ---------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < STORE_SIZE; i++) begin
         frame_copy[i] = 8'h00;
      end
      invert_on = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      // The block sweeps its store to zero after reset before it takes commands.
      repeat (2) @(posedge clock);
      while (busy)
         @(posedge clock);

      // Directed part with inversion disabled: corner pixels, glyphs at the
      // edges, blank and clipped glyphs, an invert that must do nothing, the
      // unused codes, and fetches with and without the command preamble.
      write_invert(1'b0);
      queue_cmd(OP_SET, 0, 0, 0, 1'b1, 8'h00);
      queue_cmd(OP_SET, COLUMNS - 1, PAGES * 8 - 1, 0, 1'b1, 8'h00);
      queue_cmd(OP_SET, 64, 13, 0, 1'b1, 8'h00);
      queue_cmd(OP_SET, 64, 13, 0, 1'b0, 8'h00);
      queue_cmd(OP_PRINT, 0, 0, 0, 1'b0, CHAR_A);
      queue_cmd(OP_PRINT, 6, 0, 1, 1'b0, CHAR_DOT);
      queue_cmd(OP_PRINT, 12, 0, 1, 1'b0, CHAR_COLON);
      queue_cmd(OP_PRINT, 18, 0, 2, 1'b0, 8'hff);
      queue_cmd(OP_PRINT, 24, 0, 2, 1'b0, CHAR_ZERO);
      queue_cmd(OP_PRINT, 30, 0, 2, 1'b0, CHAR_NINE);
      queue_cmd(OP_PRINT, 36, 0, 3, 1'b0, CHAR_Z);
      // A wide glyph that only partly fits at the right edge.
      queue_cmd(OP_PRINT, COLUMNS - 3, 0, 2, 1'b0, "W");
      queue_cmd(OP_INVERT, 0, 0, 0, 1'b0, 8'h00);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
         queue_cmd(3'(op), 0, 0, 0, 1'b0, 8'h00);
      queue_cmd(OP_FETCH, 0, 0, 0, 1'b0, 8'h00);
      queue_cmd(OP_FETCH, 1, 0, 0, 1'b0, 8'h00);
      queue_cmd(OP_FETCH, COLUMNS - 1, 0, PAGES - 1, 1'b0, 8'h00);
      queue_cmd(OP_FETCH, COLUMNS - 1, 0, 2, 1'b0, 8'h00);
      wait_drained();

      // Inversion enabled: invert, read back, clear, then invert the empty store.
      write_invert(1'b1);
      queue_cmd(OP_INVERT, 0, 0, 0, 1'b0, 8'h00);
      queue_cmd(OP_FETCH, 0, 0, PAGES - 1, 1'b0, 8'h00);
      queue_cmd(OP_FETCH, COLUMNS - 3, 0, 2, 1'b0, 8'h00);
      queue_cmd(OP_CLEAR, 0, 0, 0, 1'b0, 8'h00);
      queue_cmd(OP_INVERT, 0, 0, 0, 1'b0, 8'h00);
      queue_cmd(OP_FETCH, 0, 0, 0, 1'b0, 8'h00);
      wait_drained();

      // Random part, switching the invert register between phases.
      write_invert(1'b0);
      queue_random(80);
      wait_drained();

      write_invert(1'b1);
      queue_random(80);
      wait_drained();

      // Last phase runs back to back with no idle cycles on the request side.
      write_invert(1'b0);
      write_invert(1'b1);
      steady_feed = 1'b1;
      queue_random(90);
      wait_drained();

      // Give any stray beat time to show up before the verdict.
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
